FILE: src/nvme_prp_pkg.sv
// Shared types, codes and constants of the NVMe I/O submit and PRP engine.
package nvme_prp_pkg;

  // Parameter defaults
  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned MAX_PRP_DEF     = 32;

  // Field widths fixed by the interface
  localparam int unsigned EXTRA_W    = 6;   // holds any list length up to 63
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned DB_W       = 12;
  localparam int unsigned STATUS_W   = 15;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned FIFO_DEPTH = 2;

  // Shift limits and reset values
  localparam logic [4:0] PAGE_SHIFT_MIN  = 5'd12;
  localparam logic [4:0] PAGE_SHIFT_MAX  = 5'd16;
  localparam logic [4:0] BLOCK_SHIFT_MIN = 5'd9;
  localparam logic [4:0] BLOCK_SHIFT_MAX = 5'd16;
  localparam logic [4:0] PAGE_SHIFT_RST  = 5'd12;
  localparam logic [4:0] BLOCK_SHIFT_RST = 5'd9;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SHIFT   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAPPING_BASE  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRP_LIST_BASE = 4'd3;

  // Command opcodes
  localparam logic [1:0] OPC_NONE  = 2'd0;
  localparam logic [1:0] OPC_WRITE = 2'd1;
  localparam logic [1:0] OPC_READ  = 2'd2;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_PRP_ENTRY = 3'd0,
    KIND_COMMAND   = 3'd1,
    KIND_CPL_DONE  = 3'd2,
    KIND_NOT_READY = 3'd3,
    KIND_TOO_LARGE = 3'd4
  } kind_e;

  // Active configuration, shifts already clamped
  typedef struct packed {
    logic [4:0]  page_shift;
    logic [4:0]  block_shift;
    logic [63:0] mapping_base;
    logic [63:0] prp_list_base;
  } cfg_t;

  // One input request
  typedef struct packed {
    logic                action;
    logic [63:0]         buffer_address;
    logic [63:0]         start_lba;
    logic [16:0]         block_count;
    logic [31:0]         namespace_id;
    logic                is_write;
    logic                completion_phase;
    logic [STATUS_W-1:0] completion_status;
  } in_item_t;

  // Classified request handed from front to back
  typedef struct packed {
    logic                action;
    logic                too_large;
    logic [EXTRA_W-1:0]  extra;
    logic [63:0]         phys;
    logic [63:0]         base;
    logic [63:0]         lba;
    logic [15:0]         len;
    logic [31:0]         nsid;
    logic                is_write;
    logic                cph;
    logic [STATUS_W-1:0] status;
  } desc_t;

  // One result
  typedef struct packed {
    kind_e               kind;
    logic [SLOT_W-1:0]   slot;
    logic [1:0]          opcode;
    logic [31:0]         cmd_namespace;
    logic [63:0]         cmd_lba;
    logic [15:0]         length_field;
    logic [63:0]         first_prp;
    logic [63:0]         second_prp;
    logic [DB_W-1:0]     doorbell_value;
    logic [STATUS_W-1:0] status;
    logic                success;
    logic                last;
  } res_t;

endpackage

FILE: src/nvme_prp_front.sv
// Front end: takes requests, works out physical addresses and the PRP page count.
module nvme_prp_front #(
  parameter int unsigned MAX_PRP_ENTRIES = nvme_prp_pkg::MAX_PRP_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  nvme_prp_pkg::cfg_t      cfg_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  nvme_prp_pkg::in_item_t  in_item_i,
  output logic                    push_o,
  input  logic                    q_ready_i,
  output nvme_prp_pkg::desc_t     desc_o
);
  import nvme_prp_pkg::*;

  logic        accept;
  logic [16:0] page_mask;
  logic [15:0] offset;
  logic [63:0] buf_aligned;

  logic                a_valid_q;
  logic                action_q;
  logic                bad_q;
  logic [63:0]         phys_q;
  logic [63:0]         base_q;
  logic [33:0]         span_q;
  logic [63:0]         lba_q;
  logic [15:0]         len_q;
  logic [31:0]         nsid_q;
  logic                wr_q;
  logic                cph_q;
  logic [STATUS_W-1:0] status_q;

  logic [34:0] rounded;
  logic [34:0] pages;
  logic [34:0] extra_w;

  assign push_o     = a_valid_q && q_ready_i;
  assign in_ready_o = !a_valid_q || push_o;
  assign accept     = in_valid_i && in_ready_o;

  // Page offset and aligned buffer address
  assign page_mask   = (17'd1 << cfg_i.page_shift) - 17'd1;
  assign offset      = in_item_i.buffer_address[15:0] & page_mask[15:0];
  assign buf_aligned = {in_item_i.buffer_address[63:16],
                        in_item_i.buffer_address[15:0] & ~page_mask[15:0]};

  // Stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (accept) begin
      a_valid_q <= 1'b1;
    end else if (push_o) begin
      a_valid_q <= 1'b0;
    end
  end

  // Stage payload: both address subtractions and the byte span
  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= in_item_i.action;
      bad_q    <= (in_item_i.block_count == 17'd0) ||
                  (in_item_i.block_count[16] && (in_item_i.block_count[15:0] != 16'd0));
      phys_q   <= in_item_i.buffer_address - cfg_i.mapping_base;
      base_q   <= buf_aligned - cfg_i.mapping_base;
      span_q   <= 34'(offset) + (34'(in_item_i.block_count) << cfg_i.block_shift);
      lba_q    <= in_item_i.start_lba;
      len_q    <= in_item_i.block_count[15:0] - 16'd1;
      nsid_q   <= in_item_i.namespace_id;
      wr_q     <= in_item_i.is_write;
      cph_q    <= in_item_i.completion_phase;
      status_q <= in_item_i.completion_status;
    end
  end

  // Extra pages beyond the first: ceil(span / page) - 1
  assign rounded = 35'(span_q) + ((35'd1 << cfg_i.page_shift) - 35'd1);
  assign pages   = rounded >> cfg_i.page_shift;
  assign extra_w = pages - 35'd1;

  always_comb begin
    desc_o           = '0;
    desc_o.action    = action_q;
    desc_o.too_large = bad_q || (extra_w > 35'(MAX_PRP_ENTRIES));
    desc_o.extra     = extra_w[EXTRA_W-1:0];
    desc_o.phys      = phys_q;
    desc_o.base      = base_q;
    desc_o.lba       = lba_q;
    desc_o.len       = len_q;
    desc_o.nsid      = nsid_q;
    desc_o.is_write  = wr_q;
    desc_o.cph       = cph_q;
    desc_o.status    = status_q;
  end

endmodule

FILE: src/nvme_prp_fifo.sv
// Short request queue between front and back ends.
module nvme_prp_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  nvme_prp_pkg::desc_t desc_i,
  output logic                ready_o,
  output logic                valid_o,
  input  logic                pop_i,
  output nvme_prp_pkg::desc_t desc_o
);
  import nvme_prp_pkg::*;

  localparam int unsigned PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

  desc_t          mem_q [FIFO_DEPTH];
  logic [PW-1:0]  wr_ptr_q;
  logic [PW-1:0]  rd_ptr_q;
  logic [CW-1:0]  count_q;
  logic           do_push;
  logic           do_pop;

  assign ready_o = (count_q != CW'(FIFO_DEPTH));
  assign valid_o = (count_q != '0);
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign desc_o  = mem_q[rd_ptr_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= desc_i;
    end
  end

endmodule

FILE: src/nvme_prp_back.sv
// Back end: sequences PRP list entries and commands, tracks queue tail, head and phase.
module nvme_prp_back #(
  parameter int unsigned QUEUE_DEPTH = nvme_prp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nvme_prp_pkg::cfg_t  cfg_i,
  input  logic                q_valid_i,
  input  nvme_prp_pkg::desc_t q_desc_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output nvme_prp_pkg::res_t  out_res_o
);
  import nvme_prp_pkg::*;

  localparam int unsigned TW = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LIST = 2'd1;
  localparam logic [1:0] ST_CMD  = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [TW-1:0]      tail_q, tail_d;
  logic [TW-1:0]      head_q, head_d;
  logic               phase_q, phase_d;
  logic [EXTRA_W-1:0] idx_q, idx_d;
  logic [63:0]        addr_q, addr_d;
  desc_t              cur_q, cur_d;
  logic               out_valid_q;
  res_t               res_q, res_d;
  logic               emit;
  logic               out_free;
  logic [63:0]        page;
  logic [TW-1:0]      tail_nxt;
  logic [TW-1:0]      head_nxt;
  logic [DB_W-1:0]    tail_ext;

  function automatic res_t build_cmd(input desc_t d, input logic [SLOT_W-1:0] slot,
                                     input logic [DB_W-1:0] db, input logic [63:0] prp2);
    res_t r;
    r                = '0;
    r.kind           = KIND_COMMAND;
    r.slot           = slot;
    r.opcode         = d.is_write ? OPC_WRITE : OPC_READ;
    r.cmd_namespace  = d.nsid;
    r.cmd_lba        = d.lba;
    r.length_field   = d.len;
    r.first_prp      = d.phys;
    r.second_prp     = prp2;
    r.doorbell_value = db;
    r.last           = 1'b1;
    return r;
  endfunction

  assign out_free    = !out_valid_q || out_ready_i;
  assign page        = 64'd1 << cfg_i.page_shift;
  assign tail_nxt    = (tail_q == TW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
  assign head_nxt    = (head_q == TW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_ext    = DB_W'(tail_q);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  // Sequencer
  always_comb begin
    state_d = state_q;
    tail_d  = tail_q;
    head_d  = head_q;
    phase_d = phase_q;
    idx_d   = idx_q;
    addr_d  = addr_q;
    cur_d   = cur_q;
    emit    = 1'b0;
    pop_o   = 1'b0;
    res_d   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i && out_free) begin
          pop_o = 1'b1;
          if (q_desc_i.action) begin
            emit       = 1'b1;
            res_d.last = 1'b1;
            if (q_desc_i.cph == phase_q) begin
              res_d.kind           = KIND_NOT_READY;
              res_d.doorbell_value = DB_W'(head_q);
            end else begin
              head_d = head_nxt;
              if (head_q == TW'(QUEUE_DEPTH - 1)) begin
                phase_d = !phase_q;
              end
              res_d.kind           = KIND_CPL_DONE;
              res_d.doorbell_value = DB_W'(head_nxt);
              res_d.status         = q_desc_i.status;
              res_d.success        = (q_desc_i.status == '0);
            end
          end else if (q_desc_i.too_large) begin
            emit       = 1'b1;
            res_d.kind = KIND_TOO_LARGE;
            res_d.last = 1'b1;
          end else if (q_desc_i.extra >= EXTRA_W'(2)) begin
            cur_d   = q_desc_i;
            addr_d  = q_desc_i.base + page;
            idx_d   = '0;
            state_d = ST_LIST;
          end else begin
            emit   = 1'b1;
            tail_d = tail_nxt;
            res_d  = build_cmd(q_desc_i, tail_ext[SLOT_W-1:0], DB_W'(tail_nxt),
                               (q_desc_i.extra == '0) ? 64'd0 : q_desc_i.base + page);
          end
        end
      end
      ST_LIST: begin
        if (out_free) begin
          emit            = 1'b1;
          res_d.kind      = KIND_PRP_ENTRY;
          res_d.slot      = SLOT_W'(idx_q);
          res_d.first_prp = addr_q;
          addr_d          = addr_q + page;
          if (idx_q == cur_q.extra - 1'b1) begin
            state_d = ST_CMD;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ST_CMD: begin
        if (out_free) begin
          emit    = 1'b1;
          tail_d  = tail_nxt;
          res_d   = build_cmd(cur_q, tail_ext[SLOT_W-1:0], DB_W'(tail_nxt),
                              cfg_i.prp_list_base);
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tail_q      <= '0;
      head_q      <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      tail_q  <= tail_d;
      head_q  <= head_d;
      phase_q <= phase_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working payload and output register
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    addr_q <= addr_d;
    cur_q  <= cur_d;
    if (emit) begin
      res_q <= res_d;
    end
  end

endmodule

FILE: src/nvme_io_submit_prp_engine.sv
// Top level of the NVMe I/O submit engine with PRP list generation.
//
//  channel   direction  handshake                       payload
//  s_axis    in         s_axis_tvalid / s_axis_tready   tdata 200 b, tuser 1 b
//  m_axis    out        m_axis_tvalid / m_axis_tready   tdata 280 b, tuser 3 b, tlast
//  cfg       in         cfg_valid_i / cfg_ready_o       cfg_index_i 4 b, cfg_data_i 64 b
//
// A completion, an oversized request or a submit with at most one extra page gives one
// sequencer result; a submit with a PRP list of N entries steps through list set-up, N
// entries and command, one result a cycle from the back-end sequencer while the output
// is not stalled. The front end registers requests and runs ahead via a two-entry queue.
// Reset clears queue tail, completion head and phase, and loads the register defaults.
// A stalled output holds its result; the front keeps taking requests until the queue fills.
module nvme_io_submit_prp_engine #(
  parameter int unsigned QUEUE_DEPTH     = nvme_prp_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned MAX_PRP_ENTRIES = nvme_prp_pkg::MAX_PRP_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // buffer_address, start_lba, block_count, namespace_id, is_write,
  // completion_phase, completion_status, zero pad
  input  logic [199:0]                        s_axis_tdata,
  // action
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // slot, opcode, cmd_namespace, cmd_lba, length_field, first_prp, second_prp,
  // doorbell_value, status, success, zero pad
  output logic [279:0]                        m_axis_tdata,
  // kind
  output logic [2:0]                          m_axis_tuser,
  output logic                                m_axis_tlast,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [nvme_prp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [63:0]                         cfg_data_i
);
  import nvme_prp_pkg::*;

  logic [4:0]  page_shift_q;
  logic [4:0]  block_shift_q;
  logic [63:0] mapping_base_q;
  logic [63:0] prp_list_base_q;
  cfg_t        cfg;
  in_item_t    in_item;
  logic        push;
  logic        q_ready;
  desc_t       front_desc;
  logic        q_valid;
  logic        pop;
  desc_t       q_desc;
  res_t        res;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_shift_q    <= PAGE_SHIFT_RST;
      block_shift_q   <= BLOCK_SHIFT_RST;
      mapping_base_q  <= '0;
      prp_list_base_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_PAGE_SHIFT:    page_shift_q    <= cfg_data_i[4:0];
        CFG_BLOCK_SHIFT:   block_shift_q   <= cfg_data_i[4:0];
        CFG_MAPPING_BASE:  mapping_base_q  <= cfg_data_i;
        CFG_PRP_LIST_BASE: prp_list_base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamped shifts
  always_comb begin
    cfg.page_shift    = (page_shift_q < PAGE_SHIFT_MIN) ? PAGE_SHIFT_MIN :
                        (page_shift_q > PAGE_SHIFT_MAX) ? PAGE_SHIFT_MAX : page_shift_q;
    cfg.block_shift   = (block_shift_q < BLOCK_SHIFT_MIN) ? BLOCK_SHIFT_MIN :
                        (block_shift_q > BLOCK_SHIFT_MAX) ? BLOCK_SHIFT_MAX : block_shift_q;
    cfg.mapping_base  = mapping_base_q;
    cfg.prp_list_base = prp_list_base_q;
  end

  // Input unpacking
  always_comb begin
    in_item.action            = s_axis_tuser;
    in_item.buffer_address    = s_axis_tdata[63:0];
    in_item.start_lba         = s_axis_tdata[127:64];
    in_item.block_count       = s_axis_tdata[144:128];
    in_item.namespace_id      = s_axis_tdata[176:145];
    in_item.is_write          = s_axis_tdata[177];
    in_item.completion_phase  = s_axis_tdata[178];
    in_item.completion_status = s_axis_tdata[193:179];
  end

  nvme_prp_front #(
    .MAX_PRP_ENTRIES (MAX_PRP_ENTRIES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .push_o     (push),
    .q_ready_i  (q_ready),
    .desc_o     (front_desc)
  );

  nvme_prp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (front_desc),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .pop_i   (pop),
    .desc_o  (q_desc)
  );

  nvme_prp_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_desc_i    (q_desc),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  // Output packing
  assign m_axis_tdata = {4'b0, res.success, res.status, res.doorbell_value, res.second_prp,
                         res.first_prp, res.length_field, res.cmd_lba, res.cmd_namespace,
                         res.opcode, res.slot};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

FILE: src/nvme_prp_checker.sv
// Port-level checks of the NVMe submit engine, bound to the top level.
module nvme_prp_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [279:0] m_axis_tdata,
  input logic [2:0]   m_axis_tuser,
  input logic         m_axis_tlast
);
  import nvme_prp_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // List entries never close a request, every other kind does
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser != KIND_PRP_ENTRY)))
    else $error("tlast does not match result kind");

  // Success flag follows the consumed status
  a_success: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_CPL_DONE) |->
      (m_axis_tdata[275] == (m_axis_tdata[274:260] == 15'd0)))
    else $error("success flag disagrees with status");

  // Commands carry a read or write opcode
  a_cmd_opcode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_COMMAND) |->
      (m_axis_tdata[7:6] == OPC_WRITE) || (m_axis_tdata[7:6] == OPC_READ))
    else $error("command without read or write opcode");

endmodule

bind nvme_io_submit_prp_engine nvme_prp_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

FILE: tb/nvme_io_submit_prp_engine_test.sv
// Self-checking testbench for the NVMe I/O submit engine with PRP list generation.
module nvme_io_submit_prp_engine_test;
  import nvme_prp_pkg::*;

  localparam int unsigned SQ_DEPTH       = QUEUE_DEPTH_DEF;
  localparam int unsigned PRP_LIMIT      = MAX_PRP_DEF;
  localparam int unsigned RAND_PHASES    = 5;
  localparam int unsigned RAND_PER_PHASE = 40;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned TAIL_CYCLES    = 40;
  localparam int unsigned STALL_LIMIT    = 5000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 4'd15;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // buffer_address, start_lba, block_count, namespace_id, is_write,
  // completion_phase, completion_status, zero pad
  logic [199:0]         s_axis_tdata;
  // action
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // slot, opcode, cmd_namespace, cmd_lba, length_field, first_prp, second_prp,
  // doorbell_value, status, success, zero pad
  logic [279:0]         m_axis_tdata;
  // kind
  logic [2:0]           m_axis_tuser;
  logic                 m_axis_tlast;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [63:0]          cfg_data_i;

  nvme_io_submit_prp_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Queue state, register copy and the results still due from the engine
  class nvme_queue_tracker;
    logic [4:0]  page_shift;
    logic [4:0]  block_shift;
    logic [63:0] mapping_base;
    logic [63:0] prp_list_base;
    int unsigned sq_tail;
    int unsigned cq_head;
    logic        cq_phase;
    res_t        results_due[$];
    int unsigned errors, requests, checked;
    int unsigned entries, commands, consumed, not_ready, too_large;

    function new();
      page_shift    = PAGE_SHIFT_RST;
      block_shift   = BLOCK_SHIFT_RST;
      mapping_base  = '0;
      prp_list_base = '0;
      sq_tail       = 0;
      cq_head       = 0;
      cq_phase      = 1'b0;
      errors        = 0;
      requests      = 0;
      checked       = 0;
      entries       = 0;
      commands      = 0;
      consumed      = 0;
      not_ready     = 0;
      too_large     = 0;
    endfunction

    function logic [4:0] eff_page_shift();
      if (page_shift < PAGE_SHIFT_MIN) return PAGE_SHIFT_MIN;
      if (page_shift > PAGE_SHIFT_MAX) return PAGE_SHIFT_MAX;
      return page_shift;
    endfunction

    function logic [4:0] eff_block_shift();
      if (block_shift < BLOCK_SHIFT_MIN) return BLOCK_SHIFT_MIN;
      if (block_shift > BLOCK_SHIFT_MAX) return BLOCK_SHIFT_MAX;
      return block_shift;
    endfunction

    // Unknown indexes leave the registers alone
    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
      case (idx)
        CFG_PAGE_SHIFT:    page_shift    = data[4:0];
        CFG_BLOCK_SHIFT:   block_shift   = data[4:0];
        CFG_MAPPING_BASE:  mapping_base  = data;
        CFG_PRP_LIST_BASE: prp_list_base = data;
        default: ;
      endcase
    endfunction

    function void push_too_large();
      res_t r;
      r      = '0;
      r.kind = KIND_TOO_LARGE;
      r.last = 1'b1;
      results_due.push_back(r);
      too_large++;
    endfunction

    // Work out every result an accepted request causes
    function void take_request(in_item_t it);
      res_t        r;
      logic [4:0]  ps, bs;
      logic [63:0] page, offset, phys, base, span, extra, i;
      requests++;
      r      = '0;
      r.last = 1'b1;
      if (it.action) begin
        if (it.completion_phase == cq_phase) begin
          r.kind           = KIND_NOT_READY;
          r.doorbell_value = DB_W'(cq_head);
          not_ready++;
        end else begin
          cq_head++;
          if (cq_head >= SQ_DEPTH) begin
            cq_head  = 0;
            cq_phase = ~cq_phase;
          end
          r.kind           = KIND_CPL_DONE;
          r.doorbell_value = DB_W'(cq_head);
          r.status         = it.completion_status;
          r.success        = (it.completion_status == '0);
          consumed++;
        end
        results_due.push_back(r);
        return;
      end
      ps     = eff_page_shift();
      bs     = eff_block_shift();
      page   = 64'd1 << ps;
      offset = it.buffer_address & (page - 64'd1);
      phys   = it.buffer_address - mapping_base;
      base   = phys - offset;
      if (it.block_count == '0 || it.block_count > 17'd65536) begin
        push_too_large();
        return;
      end
      span  = offset + ({47'd0, it.block_count} << bs);
      extra = ((span + page - 64'd1) >> ps) - 64'd1;
      if (extra > PRP_LIMIT) begin
        push_too_large();
        return;
      end
      // PRP list entries, one per page after the first
      if (extra >= 2) begin
        for (i = 0; i < extra; i++) begin
          r           = '0;
          r.kind      = KIND_PRP_ENTRY;
          r.slot      = SLOT_W'(i);
          r.first_prp = base + ((i + 64'd1) << ps);
          results_due.push_back(r);
          entries++;
        end
      end
      r               = '0;
      r.kind          = KIND_COMMAND;
      r.slot          = SLOT_W'(sq_tail);
      r.opcode        = it.is_write ? OPC_WRITE : OPC_READ;
      r.cmd_namespace = it.namespace_id;
      r.cmd_lba       = it.start_lba;
      r.length_field  = 16'(it.block_count - 17'd1);
      r.first_prp     = phys;
      if (extra == 0) r.second_prp = '0;
      else if (extra == 1) r.second_prp = base + page;
      else r.second_prp = prp_list_base;
      sq_tail++;
      if (sq_tail >= SQ_DEPTH) sq_tail = 0;
      r.doorbell_value = DB_W'(sq_tail);
      r.last           = 1'b1;
      results_due.push_back(r);
      commands++;
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] seen);
      if (seen !== want) begin
        $error("%s mismatch: expected %0h, got %0h", name, want, seen);
        errors++;
      end
    endfunction

    // Compare one result with the oldest one due
    function void match_result(res_t got);
      res_t want;
      checked++;
      if (results_due.size() == 0) begin
        $error("result with no request outstanding: kind %0d", got.kind);
        errors++;
        return;
      end
      want = results_due.pop_front();
      check_field("kind", 64'(want.kind), 64'(got.kind));
      check_field("slot", 64'(want.slot), 64'(got.slot));
      check_field("opcode", 64'(want.opcode), 64'(got.opcode));
      check_field("cmd_namespace", 64'(want.cmd_namespace), 64'(got.cmd_namespace));
      check_field("cmd_lba", want.cmd_lba, got.cmd_lba);
      check_field("length_field", 64'(want.length_field), 64'(got.length_field));
      check_field("first_prp", want.first_prp, got.first_prp);
      check_field("second_prp", want.second_prp, got.second_prp);
      check_field("doorbell_value", 64'(want.doorbell_value), 64'(got.doorbell_value));
      check_field("status", 64'(want.status), 64'(got.status));
      check_field("success", 64'(want.success), 64'(got.success));
      check_field("last", 64'(want.last), 64'(got.last));
    endfunction

    function int unsigned pending();
      return results_due.size();
    endfunction
  endclass

  nvme_queue_tracker tracker;
  int unsigned       burst_left;
  int unsigned       settings;
  bit                hold_req;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic in_item_t submit_req(logic [63:0] buf_addr, logic [63:0] lba,
                                          logic [16:0] count, logic [31:0] nsid,
                                          logic wr);
    in_item_t it;
    it                = '0;
    it.buffer_address = buf_addr;
    it.start_lba      = lba;
    it.block_count    = count;
    it.namespace_id   = nsid;
    it.is_write       = wr;
    return it;
  endfunction

  function automatic in_item_t completion_req(logic ph, logic [STATUS_W-1:0] st);
    in_item_t it;
    it                   = '0;
    it.action            = 1'b1;
    it.completion_phase  = ph;
    it.completion_status = st;
    return it;
  endfunction

  // Mostly well-formed requests: completions with the expected phase, and
  // transfers sized to land around the PRP list limit
  function automatic in_item_t random_request();
    in_item_t    it;
    logic [4:0]  ps, bs;
    logic [63:0] page;
    int unsigned max_cnt, sel;
    it.action            = 1'b0;
    it.buffer_address    = {$urandom, $urandom};
    it.start_lba         = {$urandom, $urandom};
    it.block_count       = 17'd1;
    it.namespace_id      = $urandom_range(1, 32'hFFFF_FFFE);
    it.is_write          = 1'($urandom_range(0, 1));
    it.completion_phase  = 1'($urandom_range(0, 1));
    it.completion_status = STATUS_W'($urandom_range(0, 32767));
    if ($urandom_range(0, 99) < 35) begin
      it.action = 1'b1;
      if ($urandom_range(0, 4) != 0) it.completion_phase = ~tracker.cq_phase;
      if ($urandom_range(0, 3) == 0) it.completion_status = '0;
      return it;
    end
    ps   = tracker.eff_page_shift();
    bs   = tracker.eff_block_shift();
    page = 64'd1 << ps;
    sel  = $urandom_range(0, 9);
    if (sel < 3) it.buffer_address = it.buffer_address & ~(page - 64'd1);
    else if (sel == 3) it.buffer_address = it.buffer_address | (page - 64'd1);
    // block count that just fills the longest list
    max_cnt = ((PRP_LIMIT + 1) << ps) >> bs;
    if (max_cnt == 0) max_cnt = 1;
    sel = $urandom_range(0, 19);
    if (sel < 8) it.block_count = 17'($urandom_range(1, max_cnt / 8 + 1));
    else if (sel < 17) it.block_count = 17'($urandom_range(1, max_cnt));
    else if (sel == 17) it.block_count = 17'($urandom_range(max_cnt, 65536));
    else if (sel == 18) it.block_count = 17'($urandom_range(65537, 131071));
    else it.block_count = '0;
    return it;
  endfunction

  // Offer one request, in bursts with random gaps between them
  task automatic send_request(input in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.action;
    s_axis_tdata  <= {6'd0, it.completion_status, it.completion_phase, it.is_write,
                      it.namespace_id, it.block_count, it.start_lba, it.buffer_address};
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.take_request(it);
  endtask

  // Let every due result drain before touching the registers
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_register(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [4:0] ps, input logic [4:0] bs,
                               input logic [63:0] mb, input logic [63:0] plb,
                               input logic [CFG_IDX_W-1:0] spare);
    wait_idle();
    // upper data bits are junk and must be ignored
    write_register(CFG_PAGE_SHIFT, {$urandom, 27'($urandom), ps});
    write_register(CFG_BLOCK_SHIFT, 64'(bs));
    write_register(CFG_MAPPING_BASE, mb);
    write_register(CFG_PRP_LIST_BASE, plb);
    // unused index must not disturb anything
    write_register(spare, {$urandom, $urandom});
    settings++;
  endtask

  // Receiver readiness: changing stall patterns, plus one long hold-off on request
  initial begin : ready_pattern
    int unsigned mode, left, k;
    mode = 0;
    left = 0;
    k    = 0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) begin
          m_axis_tready <= 1'b0;
          @(posedge clk_i);
        end
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 120);
        end
        left--;
        k++;
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ((k % 5) < 3);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // Result checking and stall watchdog
  initial begin : result_monitor
    int unsigned idle_cycles;
    res_t        got;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      idle_cycles++;
      if (rst_ni === 1'b1) begin
        if (m_axis_tvalid && m_axis_tready) begin
          got.kind           = kind_e'(m_axis_tuser);
          got.slot           = m_axis_tdata[5:0];
          got.opcode         = m_axis_tdata[7:6];
          got.cmd_namespace  = m_axis_tdata[39:8];
          got.cmd_lba        = m_axis_tdata[103:40];
          got.length_field   = m_axis_tdata[119:104];
          got.first_prp      = m_axis_tdata[183:120];
          got.second_prp     = m_axis_tdata[247:184];
          got.doorbell_value = m_axis_tdata[259:248];
          got.status         = m_axis_tdata[274:260];
          got.success        = m_axis_tdata[275];
          got.last           = m_axis_tlast;
          tracker.match_result(got);
          idle_cycles = 0;
        end
        if ((s_axis_tvalid && s_axis_tready) || (cfg_valid_i && cfg_ready_o))
          idle_cycles = 0;
      end
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    int unsigned p, n;
    tracker       = new();
    burst_left    = 0;
    settings      = 1;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests at the reset register values (4 KiB pages, 512 B blocks)
    send_request(completion_req(1'b0, 15'd5));                       // phase unchanged
    send_request(submit_req(64'd0, 64'd0, 17'd1, 32'd1, 1'b0));      // single page
    send_request(submit_req(64'h1000, '1, 17'd8, 32'hFFFF_FFFE, 1'b1));
    send_request(submit_req(64'h2000, 64'h10, 17'd9, 32'h8000_0001, 1'b0));  // two pages
    send_request(submit_req(64'hFFF, 64'h20, 17'd1, 32'd5, 1'b1));   // offset crosses page
    send_request(submit_req(64'h3000, 64'h30, 17'd24, 32'd6, 1'b0)); // short list
    send_request(submit_req(64'h40000, 64'h40, 17'd264, 32'd7, 1'b1));  // longest list
    send_request(submit_req(64'h40010, 64'h50, 17'd264, 32'd8, 1'b0));  // one past it
    send_request(submit_req(64'h5000, 64'h60, 17'd265, 32'd9, 1'b1));
    send_request(submit_req(64'h6000, 64'h70, 17'd0, 32'd10, 1'b0));    // zero count
    send_request(submit_req(64'h7000, 64'h80, 17'h1FFFF, 32'd11, 1'b1));
    send_request(submit_req(64'h8000, 64'h90, 17'h10000, 32'd12, 1'b0));
    send_request(submit_req('1, '1, 17'd1, 32'hFFFF_FFFE, 1'b1));
    send_request(completion_req(1'b1, 15'd0));                       // consumed, success
    send_request(completion_req(1'b1, 15'h7FFF));                    // consumed, error
    send_request(completion_req(1'b0, 15'h1234));

    // Register settings, each followed by random traffic
    for (p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: apply_setting(5'd12, 5'd9, {$urandom, $urandom}, {$urandom, $urandom},
                         CFG_SPARE_LO);
        1: apply_setting(5'd16, 5'd16, '1, '1, CFG_SPARE_HI);
        2: apply_setting(5'd0, 5'd31, {$urandom, $urandom}, {$urandom, $urandom},
                         CFG_SPARE_LO);
        3: apply_setting(5'd31, 5'd3, '0, {$urandom, $urandom}, CFG_SPARE_HI);
        default: apply_setting(5'($urandom_range(12, 16)), 5'($urandom_range(9, 16)),
                               {$urandom, $urandom}, '0, CFG_SPARE_LO);
      endcase
      if (p == 1) begin
        // largest page and block: one block per page
        send_request(submit_req(64'h1234_5678_9ABC_0000, 64'd1, 17'd1, 32'd2, 1'b0));
        send_request(submit_req(64'h1234_5678_9ABC_0000, 64'd2, 17'd2, 32'd3, 1'b1));
        send_request(submit_req(64'h0000_0000_0001_0000, 64'd3, 17'd33, 32'd4, 1'b0));
        send_request(submit_req(64'h0000_0000_0002_0000, 64'd4, 17'd34, 32'd5, 1'b1));
        // long receiver hold-off while requests keep coming
        hold_req = 1'b1;
      end
      for (n = 0; n < RAND_PER_PHASE; n++) send_request(random_request());
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Covered %0d requests over %0d register settings; %0d results checked.",
             tracker.requests, settings, tracker.checked);
    $display("Kinds: %0d list entries, %0d commands, %0d consumed, %0d not ready, %0d too large.",
             tracker.entries, tracker.commands, tracker.consumed, tracker.not_ready,
             tracker.too_large);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
